>>> sv/esc_pkg.sv
// Shared widths, payload types and the control group for the row
// expand-sort-compress block. No dependencies.
`default_nettype none

package esc_pkg;

    localparam int KEY_W        = 20;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 64;
    localparam int CAPACITY_DEF = 64;

    typedef logic        [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Control from the sequencer to the merge unit
    typedef struct packed {
        logic new_row;   // forget the last emitted column
        logic restart;   // drop the candidate before a fresh scan
        logic sample;    // read data is valid this cycle
        logic advance;   // candidate becomes the last emitted column
    } merge_ctrl_t;

endpackage

`default_nettype wire

>>> sv/esc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/esc_merge.sv
// Shared compare-and-accumulate unit: over one scan of the store it finds the
// smallest column above the last one emitted and sums its products.
// Depends on esc_pkg.
`default_nettype none

module esc_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire esc_pkg::merge_ctrl_t ctrl,
    input  wire esc_pkg::key_t        rd_key,
    input  wire esc_pkg::sum_t        rd_prod,
    output esc_pkg::key_t             cand_key,
    output esc_pkg::sum_t             cand_sum,
    output logic                      more
);

    import esc_pkg::*;

    key_t prev_key_reg, prev_key_next;
    logic has_prev_reg, has_prev_next;
    key_t cand_key_reg, cand_key_next;
    sum_t cand_sum_reg, cand_sum_next;
    logic found_reg,    found_next;
    logic more_reg,     more_next;
    logic eligible;

    // Compare, select and add for one stored product
    always_comb
    begin
        prev_key_next = prev_key_reg;
        has_prev_next = has_prev_reg;
        cand_key_next = cand_key_reg;
        cand_sum_next = cand_sum_reg;
        found_next    = found_reg;
        more_next     = more_reg;
        eligible      = !has_prev_reg || (rd_key > prev_key_reg);

        if (ctrl.sample && eligible)
        begin
            if (!found_reg || (rd_key < cand_key_reg))
            begin
                // new smallest column; the old candidate, if any, still waits
                cand_key_next = rd_key;
                cand_sum_next = rd_prod;
                more_next     = found_reg;
                found_next    = 1'b1;
            end
            else if (rd_key == cand_key_reg)
            begin
                cand_sum_next = cand_sum_reg + rd_prod;
            end
            else
            begin
                more_next = 1'b1;
            end
        end

        if (ctrl.advance)
        begin
            prev_key_next = cand_key_reg;
            has_prev_next = 1'b1;
        end
        if (ctrl.restart)
        begin
            found_next = 1'b0;
            more_next  = 1'b0;
        end
        if (ctrl.new_row)
        begin
            has_prev_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_prev_reg <= 1'b0;
            found_reg    <= 1'b0;
            more_reg     <= 1'b0;
        end
        else
        begin
            has_prev_reg <= has_prev_next;
            found_reg    <= found_next;
            more_reg     <= more_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        prev_key_reg <= prev_key_next;
        cand_key_reg <= cand_key_next;
        cand_sum_reg <= cand_sum_next;
    end

    assign cand_key = cand_key_reg;
    assign cand_sum = cand_sum_reg;
    assign more     = more_reg;

endmodule

`default_nettype wire

>>> sv/spgemm_row_expand_sort_compress.sv
// Top level of the row expand-sort-compress block: sequencer, multiplier and
// product store. Depends on esc_pkg, esc_ram and esc_merge.
//
// Use: drive column, a_value, b_value and row_end with start high; the
// transfer happens at the edge where start is high and busy is low. Each
// partial product is captured, then multiplied and written into the store,
// so busy is high for one cycle after every non-final transfer.
// On the transfer that carries row_end the block sorts and merges the row.
// Each result needs one full scan of the store through its single read
// port; the read data is registered and the result is then presented.
// Results leave in ascending column order, one cycle each, marked by
// out_valid; out_last flags the final one and overflowed reports that
// products beyond CAPACITY were dropped in this row. The receiver cannot
// stall: every result is held for exactly one cycle. Busy stays high until
// the last result is shown. Reset empties the store count and the drop flag
// at once; no clearing pass is needed.
`default_nettype none

module spgemm_row_expand_sort_compress #(
    parameter int CAPACITY = esc_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire esc_pkg::key_t column,
    input  wire esc_pkg::val_t a_value,
    input  wire esc_pkg::val_t b_value,
    input  wire logic          row_end,
    output logic               out_valid,
    output esc_pkg::key_t      out_column,
    output esc_pkg::sum_t      out_sum,
    output logic               out_last,
    output logic               overflowed
);

    import esc_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int WORD_W = KEY_W + SUM_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg,   idx_next;
    logic               drop_reg,  drop_next;
    logic               rd_vld_reg, rd_vld_next;
    key_t               col_reg;
    val_t               a_reg;
    val_t               b_reg;
    logic               end_reg;

    sum_t               prod;
    logic               wr_en;
    logic               rd_en;
    logic [WORD_W-1:0]  rd_word;
    merge_ctrl_t        mctrl;
    key_t               cand_key;
    sum_t               cand_sum;
    logic               more;

    // Signed 32x32 product, written straight into the store
    assign prod = sum_t'(a_reg) * sum_t'(b_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        drop_next     = drop_reg;
        rd_vld_next   = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        mctrl         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // store the product, or drop it when the store is full
                if (count_reg < CNT_W'(CAPACITY))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
                if (end_reg)
                begin
                    idx_next      = '0;
                    mctrl.new_row = 1'b1;
                    mctrl.restart = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle; the merge unit evaluates each one from the registered read data
                mctrl.sample = rd_vld_reg;
                if (idx_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (more)
                begin
                    mctrl.advance = 1'b1;
                    mctrl.restart = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            drop_reg   <= drop_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Capture the operands on a transfer
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            col_reg <= column;
            a_reg   <= a_value;
            b_reg   <= b_value;
            end_reg <= row_end;
        end
    end

    esc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({col_reg, prod}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    esc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mctrl),
        .rd_key   (rd_word[WORD_W-1:SUM_W]),
        .rd_prod  (rd_word[SUM_W-1:0]),
        .cand_key (cand_key),
        .cand_sum (cand_sum),
        .more     (more)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign out_column = cand_key;
    assign out_sum    = cand_sum;
    assign out_last   = !more;
    assign overflowed = drop_reg;

    // A result is only shown while the block is busy
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result shown while idle");

    // The final result of a row frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |=> !busy)
        else $error("block still busy after final result");

    // Another result needs a fresh scan first
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> !out_valid)
        else $error("results back to back without a scan");

    // A product inside a row makes the block busy, then frees it once it is stored
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !row_end) |=> busy ##1 !busy)
        else $error("non-final transfer not done in two cycles");

    // Dropped products are only possible with a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drop_reg) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("drop flagged with room in the store");

endmodule

`default_nettype wire

>>> tb/sv/esc_result_checker.sv
// Result checker for the row expand-sort-compress block: predicts each row's merged
// nonzeros from the accepted products and compares every result strobe against them.
// Depends on esc_pkg.
`timescale 1ns / 100ps

module esc_result_checker #(
    parameter int CAPACITY = esc_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire esc_pkg::key_t column,
    input  wire esc_pkg::val_t a_value,
    input  wire esc_pkg::val_t b_value,
    input  wire logic          row_end,
    input  wire logic          out_valid,
    input  wire esc_pkg::key_t out_column,
    input  wire esc_pkg::sum_t out_sum,
    input  wire logic          out_last,
    input  wire logic          overflowed,
    output int unsigned        mismatches,
    output int unsigned        outstanding
);

    import esc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        key_t column;
        sum_t sum;
        logic last;
        logic dropped;
    } nonzero_t;

    nonzero_t    expected_nonzeros[$];
    nonzero_t    head;
    sum_t        column_sums[key_t];
    int unsigned products_held;
    bit          row_dropped;
    int unsigned failures;

    // Accumulate one partial product into its column, or note the drop when full
    function automatic void hold_product(key_t key, val_t a, val_t b);
        sum_t product;
        product = sum_t'(a) * sum_t'(b);
        if (products_held < CAPACITY)
        begin
            if (column_sums.exists(key))
                column_sums[key] = column_sums[key] + product;
            else
                column_sums[key] = product;
            products_held++;
        end
        else
        begin
            row_dropped = 1'b1;
        end
    endfunction

    // Emit one expected nonzero per distinct column, ascending, then empty the row
    function automatic void close_row();
        int unsigned remaining;
        nonzero_t    nz;
        remaining = column_sums.num();
        foreach (column_sums[key])
        begin
            remaining--;
            nz.column  = key;
            nz.sum     = column_sums[key];
            nz.last    = (remaining == 0);
            nz.dropped = row_dropped;
            expected_nonzeros.push_back(nz);
        end
        column_sums.delete();
        products_held = 0;
        row_dropped   = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_nonzeros.delete();
            column_sums.delete();
            products_held = 0;
            row_dropped   = 1'b0;
            failures      = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare each result strobe with the oldest expected nonzero
            if (out_valid)
            begin
                if (expected_nonzeros.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: unexpected result column %h sum %h last %b ovf %b",
                                 $realtime, out_column, out_sum, out_last, overflowed);
                end
                else
                begin
                    head = expected_nonzeros.pop_front();
                    if (out_column !== head.column || out_sum !== head.sum ||
                        out_last !== head.last || overflowed !== head.dropped)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch exp col %h sum %h last %b ovf %b",
                                     $realtime, head.column, head.sum, head.last,
                                     head.dropped);
                            $display("%0t:          got col %h sum %h last %b ovf %b",
                                     $realtime, out_column, out_sum, out_last,
                                     overflowed);
                        end
                    end
                end
            end

            // Predict from the product moved by this transfer
            if (start && !busy)
            begin
                hold_product(column, a_value, b_value);
                if (row_end)
                    close_row();
            end

            mismatches  <= failures;
            outstanding <= expected_nonzeros.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for the row expand-sort-compress block: clock, reset,
// directed and random product rows with random gaps, and the verdict.
// Depends on esc_pkg, spgemm_row_expand_sort_compress and esc_result_checker.
`timescale 1ns / 100ps

module testbench;

    import esc_pkg::*;

    localparam int   CAPACITY       = CAPACITY_DEF;
    localparam int   TOTAL_PRODUCTS = 520;
    localparam int   QUIET_FROM     = 150;
    localparam int   QUIET_TO       = 300;
    localparam int   GAP_PERCENT    = 30;
    localparam int   SETTLE_CYCLES  = 100;
    localparam int   CYCLE_LIMIT    = 200000;
    localparam val_t VAL_MIN        = {1'b1, {(VAL_W-1){1'b0}}};
    localparam val_t VAL_MAX        = {1'b0, {(VAL_W-1){1'b1}}};
    localparam key_t KEY_MAX        = '1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    key_t        column;
    val_t        a_value;
    val_t        b_value;
    logic        row_end;
    logic        out_valid;
    key_t        out_column;
    sum_t        out_sum;
    logic        out_last;
    logic        overflowed;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned products_sent = 0;
    int unsigned cycle_count = 0;

    always #5 clk = ~clk;

    spgemm_row_expand_sort_compress #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .column     (column),
        .a_value    (a_value),
        .b_value    (b_value),
        .row_end    (row_end),
        .out_valid  (out_valid),
        .out_column (out_column),
        .out_sum    (out_sum),
        .out_last   (out_last),
        .overflowed (overflowed)
    );

    esc_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .column      (column),
        .a_value     (a_value),
        .b_value     (b_value),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_column  (out_column),
        .out_sum     (out_sum),
        .out_last    (out_last),
        .overflowed  (overflowed),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Operand values weighted towards the extremes
    function automatic val_t pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return VAL_MIN;
        else if (r < 20)
            return VAL_MAX;
        else if (r < 25)
            return val_t'(-1);
        else if (r < 28)
            return '0;
        else if (r < 40)
            return val_t'($urandom_range(0, 15)) - val_t'(8);
        else
            return val_t'($urandom);
    endfunction

    // Drop start for a random gap, with noise on the fields; none in the quiet stretch
    task automatic pause_feed();
        int unsigned gap;
        if ((products_sent >= QUIET_FROM && products_sent < QUIET_TO) ||
            $urandom_range(0, 99) >= GAP_PERCENT)
            return;
        gap = $urandom_range(1, 3);
        start   <= 1'b0;
        column  <= key_t'($urandom);
        a_value <= val_t'($urandom);
        b_value <= val_t'($urandom);
        row_end <= 1'(($urandom));
        repeat (gap) @(posedge clk);
    endtask

    // Present one partial product and hold it until the transfer
    task automatic send_product(key_t key, val_t a, val_t b, logic last);
        start   <= 1'b1;
        column  <= key;
        a_value <= a;
        b_value <= b;
        row_end <= last;
        do
            @(posedge clk);
        while (busy);
        products_sent++;
        pause_feed();
    endtask

    // One complete row: narrow rows crowd their columns together to force merging
    task automatic send_row(int unsigned len, bit narrow);
        key_t        base;
        key_t        key;
        int unsigned r;
        base = key_t'($urandom);
        for (int unsigned i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                key = '0;
            else if (r < 8)
                key = KEY_MAX;
            else if (narrow)
                key = base + key_t'($urandom_range(0, 7));
            else
                key = key_t'($urandom);
            send_product(key, pick_value(), pick_value(), i == len - 1);
        end
    endtask

    initial
    begin
        int unsigned r;
        int unsigned len;
        rst_n   = 1'b0;
        start   = 1'b0;
        column  = '0;
        a_value = '0;
        b_value = '0;
        row_end = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-product row at the bottom column with the largest product
        send_product('0, VAL_MIN, VAL_MIN, 1'b1);

        // Descending keys, then back to the top column, with it repeated and mixed signs
        send_product(KEY_MAX, VAL_MAX, VAL_MIN, 1'b0);
        send_product(KEY_MAX, VAL_MIN, VAL_MAX, 1'b0);
        send_product(key_t'(20'h80000), 1, 0, 1'b0);
        send_product('0, -1, 1, 1'b0);
        send_product(KEY_MAX, VAL_MAX, VAL_MAX, 1'b1);

        // Column sums that wrap past 64 bits, both upwards and downwards
        send_product(key_t'(5), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(5), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(5), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(5), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(6), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(6), VAL_MIN, VAL_MIN, 1'b0);
        send_product(key_t'(9), VAL_MAX, VAL_MIN, 1'b0);
        send_product(key_t'(9), VAL_MAX, VAL_MIN, 1'b0);
        send_product(key_t'(9), VAL_MAX, VAL_MIN, 1'b0);
        send_product(key_t'(6), VAL_MIN, VAL_MIN, 1'b1);

        // Interleaved equal keys, one column cancelling to zero
        send_product(key_t'(2), 3, 4, 1'b0);
        send_product(key_t'(1), 5, 6, 1'b0);
        send_product(key_t'(10), 6, 7, 1'b0);
        send_product(key_t'(2), -7, 8, 1'b0);
        send_product(key_t'(10), -6, 7, 1'b0);
        send_product(key_t'(1), 9, -10, 1'b1);

        // Store exactly full, then one and several products past capacity
        send_row(CAPACITY, 1'b0);
        send_row(CAPACITY + 1, 1'b1);
        send_row(CAPACITY + 5, 1'b0);

        // Random rows, mostly short, a few near or beyond capacity
        while (products_sent < TOTAL_PRODUCTS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 93)
                len = $urandom_range(9, 30);
            else
                len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
            send_row(len, $urandom_range(0, 99) < 60);
        end

        // Drain the outstanding results, then allow time for strays
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
